>>> sv/fws_pkg.sv
`default_nettype none

package fws_pkg;

   // fraction bits of the quantized fog exponent
   localparam int EXP_TABLE_BITS = 8;
   localparam int EXP_STEPS      = EXP_TABLE_BITS + 4;
   localparam int XQ_W           = 17 + EXP_TABLE_BITS;
   localparam int FOG_LAT        = EXP_STEPS + 3;
   localparam int FRES_LAT       = 4;

   localparam logic [15:0] IOR_ONE   = 16'd4096;
   localparam logic [15:0] IOR_MAX   = 16'd16384;
   localparam logic [15:0] IOR_WATER = 16'd5460;
   localparam logic [15:0] IOR_GLASS = 16'd6144;
   localparam logic [16:0] ONE16     = 17'd65536;

   localparam logic [1:0] CLASS_WATER   = 2'd0;
   localparam logic [1:0] CLASS_GLASS   = 2'd1;
   localparam logic [1:0] CLASS_UNKNOWN = 2'd2;

   localparam int DIV_STEPS = 45;

   // exp(-2^k), Q0.24, k = -12 .. 3
   localparam logic [23:0] EXP_POW [16] = '{
      24'd16773120, 24'd16769026, 24'd16760840, 24'd16744480,
      24'd16711808, 24'd16646655, 24'd16517109, 24'd16261035,
      24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
      24'd6171993,  24'd2270549,  24'd307285,   24'd5628
   };

   typedef enum logic [2:0] {
      CSR_HAS_IOR     = 3'd0,
      CSR_CAPTURED    = 3'd1,
      CSR_CLASS       = 3'd2,
      CSR_BIAS        = 3'd3,
      CSR_FOG_DENSITY = 3'd4,
      CSR_FOG_COLOUR  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      F0_IDLE,
      F0_SQUARE,
      F0_DIVIDE
   } f0_state_type;

   typedef struct packed {
      logic        has_captured_ior;
      logic [15:0] captured_ior;
      logic [1:0]  surface_class;
      logic [15:0] fresnel_bias;
      logic [15:0] fog_density;
      logic [47:0] fog_colour;
   } cfg_type;

   typedef struct packed {
      logic [15:0] reflect_red;
      logic [15:0] reflect_green;
      logic [15:0] reflect_blue;
      logic [15:0] refract_red;
      logic [15:0] refract_green;
      logic [15:0] refract_blue;
      logic [15:0] view_cosine;
      logic [15:0] water_distance;
   } req_type;

   typedef struct packed {
      logic [15:0] shade_red;
      logic [15:0] shade_green;
      logic [15:0] shade_blue;
   } rsp_type;

   // (a*b + 0.5) in Q1.16, operands at most 1.0
   function automatic logic [16:0] mul16(input logic [16:0] a, input logic [16:0] b);
      logic [33:0] p;
      p = {17'b0, a} * {17'b0, b} + 34'd32768;
      return p[32:16];
   endfunction

endpackage

`default_nettype wire

>>> sv/fws_f0_unit.sv
`default_nettype none

module fws_f0_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire fws_pkg::cfg_type cfg,
   output logic                  busy,
   output logic [16:0]           f0
);

   fws_pkg::f0_state_type state_ff, state_in;
   logic [28:0] den_ff;
   logic [28:0] rem_ff;
   logic [44:0] work_ff;
   logic [5:0]  count_ff;
   logic [16:0] f0_ff;

   logic [15:0] n;
   logic        use_index;
   logic        divide_sel;
   logic [13:0] n_minus;
   logic [14:0] n_plus;
   logic [27:0] num;
   logic [28:0] den;
   logic [16:0] bias_f0;
   logic [29:0] rem2;
   logic        q_bit;
   logic        last_step;

   always_comb begin
      use_index = 1'b1;
      n = 16'd0;
      if (cfg.has_captured_ior) begin
         if (cfg.captured_ior < fws_pkg::IOR_ONE || cfg.captured_ior > fws_pkg::IOR_MAX) begin
            use_index = 1'b0;
         end else begin
            n = cfg.captured_ior;
         end
      end else if (cfg.surface_class == fws_pkg::CLASS_WATER) begin
         n = fws_pkg::IOR_WATER;
      end else if (cfg.surface_class == fws_pkg::CLASS_GLASS) begin
         n = fws_pkg::IOR_GLASS;
      end
      divide_sel = use_index && (n > fws_pkg::IOR_ONE);
      n_minus = 14'(n - fws_pkg::IOR_ONE);
      n_plus  = 15'(n + fws_pkg::IOR_ONE);
      num = {14'b0, n_minus} * {14'b0, n_minus};
      den = {14'b0, n_plus} * {14'b0, n_plus};

      if (cfg.fresnel_bias[15]) begin
         bias_f0 = 17'd0;
      end else if (cfg.fresnel_bias > fws_pkg::IOR_ONE) begin
         bias_f0 = fws_pkg::ONE16;
      end else begin
         bias_f0 = {cfg.fresnel_bias[12:0], 4'b0};
      end

      rem2  = {rem_ff, work_ff[44]};
      q_bit = rem2 >= {1'b0, den_ff};
      last_step = count_ff == 6'(fws_pkg::DIV_STEPS - 1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fws_pkg::F0_IDLE: begin
            state_in = fws_pkg::F0_IDLE;
         end
         fws_pkg::F0_SQUARE: begin
            state_in = divide_sel ? fws_pkg::F0_DIVIDE : fws_pkg::F0_IDLE;
         end
         fws_pkg::F0_DIVIDE: begin
            if (last_step) state_in = fws_pkg::F0_IDLE;
         end
         default: begin
            state_in = fws_pkg::F0_IDLE;
         end
      endcase
      if (start) state_in = fws_pkg::F0_SQUARE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fws_pkg::F0_SQUARE;
      end else begin
         state_ff <= state_in;
      end
   end

   // restoring division, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (state_ff == fws_pkg::F0_SQUARE) begin
         den_ff   <= den;
         work_ff  <= {num, 17'b0} + {17'b0, den[28:1]} - {num, 17'b0} + {1'b0, num, 16'b0};
         rem_ff   <= 29'd0;
         count_ff <= 6'd0;
         if (!divide_sel) f0_ff <= bias_f0;
      end else if (state_ff == fws_pkg::F0_DIVIDE) begin
         rem_ff   <= q_bit ? 29'(rem2 - {1'b0, den_ff}) : rem2[28:0];
         work_ff  <= {work_ff[43:0], q_bit};
         count_ff <= count_ff + 6'd1;
         if (last_step) f0_ff <= {work_ff[15:0], q_bit};
      end
   end

   assign busy = state_ff != fws_pkg::F0_IDLE;
   assign f0   = f0_ff;

endmodule

`default_nettype wire

>>> sv/fws_fresnel.sv
`default_nettype none

module fws_fresnel (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [15:0] view_cosine,
   input  wire logic [16:0] f0,
   output logic [16:0]      f
);

   logic [15:0] c;
   logic [16:0] comp;
   logic [16:0] comp1_ff, comp2_ff;
   logic [16:0] sq_ff, sq2_ff, p5_ff, f_ff;
   logic [17:0] fsum;

   always_comb begin
      c    = view_cosine[15] ? 16'd0 : view_cosine;
      comp = {16'(16'd32768 - c), 1'b0};
      fsum = {1'b0, f0} + {1'b0, fws_pkg::mul16(fws_pkg::ONE16 - f0, p5_ff)};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         comp1_ff <= comp;
         sq_ff    <= fws_pkg::mul16(comp, comp);
         comp2_ff <= comp1_ff;
         sq2_ff   <= fws_pkg::mul16(sq_ff, sq_ff);
         p5_ff    <= fws_pkg::mul16(sq2_ff, comp2_ff);
         f_ff     <= (fsum > {1'b0, fws_pkg::ONE16}) ? fws_pkg::ONE16 : fsum[16:0];
      end
   end

   assign f = f_ff;

endmodule

`default_nettype wire

>>> sv/fws_fog_exp.sv
`default_nettype none

module fws_fog_exp (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [15:0] fog_density,
   input  wire logic [15:0] water_distance,
   output logic [16:0]      t
);

   localparam int B = fws_pkg::EXP_TABLE_BITS;
   localparam int N = fws_pkg::EXP_STEPS;
   localparam int W = fws_pkg::XQ_W;

   logic [31:0]  x_ff;
   logic         on1_ff;
   logic [32:0]  xsum;
   logic [W-1:0] xq_ff  [N+1];
   logic         on_ff  [N+1];
   logic         big_ff [N+1];
   logic [24:0]  t_ff   [N+1];
   logic [16:0]  t_out_ff;
   logic [25:0]  t_round;

   assign xsum = {1'b0, x_ff} + 33'(1 << (15 - B));

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff      <= {16'b0, fog_density} * {16'b0, water_distance};
         on1_ff    <= (fog_density != 16'd0) && (water_distance != 16'd0);
         xq_ff[0]  <= xsum[32:16-B];
         on_ff[0]  <= on1_ff;
         big_ff[0] <= xsum[32:16-B+N] != '0;
         t_ff[0]   <= 25'd1 << 24;
      end
   end

   // one table factor per exponent bit, lowest bit first
   for (genvar j = 0; j < N; j++) begin : g_step
      localparam int K = j + 12 - B;
      logic [48:0] p;
      assign p = {24'b0, t_ff[j]} * {25'b0, fws_pkg::EXP_POW[K]} + 49'(1 << 23);
      always_ff @(posedge clock) begin
         if (en) begin
            xq_ff[j+1]  <= xq_ff[j];
            on_ff[j+1]  <= on_ff[j];
            big_ff[j+1] <= big_ff[j];
            t_ff[j+1]   <= xq_ff[j][j] ? p[48:24] : t_ff[j];
         end
      end
   end

   assign t_round = {1'b0, t_ff[N]} + 26'd128;

   always_ff @(posedge clock) begin
      if (en) begin
         if (!on_ff[N]) begin
            t_out_ff <= fws_pkg::ONE16;
         end else if (big_ff[N]) begin
            t_out_ff <= 17'd0;
         end else begin
            t_out_ff <= t_round[24:8];
         end
      end
   end

   assign t = t_out_ff;

endmodule

`default_nettype wire

>>> sv/fresnel_fog_water_shade.sv
// Throughput: one request per cycle, set by the fully pipelined fog exponent chain, while
// the response is not held and the f0 sequencer is not busy. After reset and after every
// register write, the f0 sequencer stalls requests through its square state, and through
// its divide state as well when a refraction index must be divided out.
// Reset is synchronous, active high; configuration and valid registers return to defaults.
`default_nettype none

module fresnel_fog_water_shade (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire fws_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output fws_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [47:0]      csr_data
);

   localparam int FL    = fws_pkg::FOG_LAT;
   localparam int DLY   = fws_pkg::FOG_LAT - fws_pkg::FRES_LAT;
   localparam int DEPTH = FL + 3;

   fws_pkg::cfg_type cfg_ff;
   logic             csr_wr;
   logic             f0_busy;
   logic [16:0]      f0;

   // pipeline control: whole pipe advances unless the response is held
   logic             en;
   logic             accept;
   logic [DEPTH-1:0] vld_ff;

   fws_pkg::req_type req_ff;
   fws_pkg::req_type col_ff [FL];
   logic [16:0]      f_dly_ff [DLY];
   logic [16:0]      f_pipe;
   logic [16:0]      t_pipe;

   // blend stage
   logic [15:0]      refl [3];
   logic [15:0]      refr [3];
   logic [15:0]      fogc [3];
   logic [15:0]      fogged_ff [3];
   logic [15:0]      refl_ff [3];
   logic [16:0]      f_ff;
   logic [15:0]      shade_ff [3];
   logic [33:0]      fog_sum [3];
   logic [33:0]      mix_sum [3];

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.has_captured_ior <= 1'b0;
         cfg_ff.captured_ior     <= fws_pkg::IOR_ONE;
         cfg_ff.surface_class    <= fws_pkg::CLASS_UNKNOWN;
         cfg_ff.fresnel_bias     <= 16'd0;
         cfg_ff.fog_density      <= 16'd0;
         cfg_ff.fog_colour       <= 48'd0;
      end else if (csr_wr) begin
         unique case (csr_index)
            fws_pkg::CSR_HAS_IOR:     cfg_ff.has_captured_ior <= csr_data[0];
            fws_pkg::CSR_CAPTURED:    cfg_ff.captured_ior     <= csr_data[15:0];
            fws_pkg::CSR_CLASS:       cfg_ff.surface_class    <= csr_data[1:0];
            fws_pkg::CSR_BIAS:        cfg_ff.fresnel_bias     <= csr_data[15:0];
            fws_pkg::CSR_FOG_DENSITY: cfg_ff.fog_density      <= csr_data[15:0];
            fws_pkg::CSR_FOG_COLOUR:  cfg_ff.fog_colour       <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // f0 depends only on registers; it is recomputed after each write
   fws_f0_unit u_f0 (
      .clock (clock),
      .reset (reset),
      .start (csr_wr),
      .cfg   (cfg_ff),
      .busy  (f0_busy),
      .f0    (f0)
   );

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en || f0_busy;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req_ff    <= req_data;
         col_ff[0] <= req_ff;
         for (int i = 1; i < FL; i++) col_ff[i] <= col_ff[i-1];
         f_dly_ff[0] <= f_pipe;
         for (int i = 1; i < DLY; i++) f_dly_ff[i] <= f_dly_ff[i-1];
      end
   end

   fws_fresnel u_fresnel (
      .clock       (clock),
      .en          (en),
      .view_cosine (req_ff.view_cosine),
      .f0          (f0),
      .f           (f_pipe)
   );

   // transmittance is 1.0 when fog is off, which leaves refract unchanged
   fws_fog_exp u_fog (
      .clock          (clock),
      .en             (en),
      .fog_density    (cfg_ff.fog_density),
      .water_distance (req_ff.water_distance),
      .t              (t_pipe)
   );

   always_comb begin
      refl[0] = col_ff[FL-1].reflect_red;
      refl[1] = col_ff[FL-1].reflect_green;
      refl[2] = col_ff[FL-1].reflect_blue;
      refr[0] = col_ff[FL-1].refract_red;
      refr[1] = col_ff[FL-1].refract_green;
      refr[2] = col_ff[FL-1].refract_blue;
      for (int ch = 0; ch < 3; ch++) begin
         fogc[ch]    = cfg_ff.fog_colour[16*ch +: 16];
         fog_sum[ch] = {18'b0, refr[ch]} * {17'b0, t_pipe}
                     + {18'b0, fogc[ch]} * {17'b0, 17'(fws_pkg::ONE16 - t_pipe)}
                     + 34'd32768;
         mix_sum[ch] = {18'b0, refl_ff[ch]} * {17'b0, f_ff}
                     + {18'b0, fogged_ff[ch]} * {17'b0, 17'(fws_pkg::ONE16 - f_ff)}
                     + 34'd32768;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff <= f_dly_ff[DLY-1];
         for (int ch = 0; ch < 3; ch++) begin
            refl_ff[ch]   <= refl[ch];
            fogged_ff[ch] <= fog_sum[ch][31:16];
            shade_ff[ch]  <= (mix_sum[ch][33:32] != 2'b0) ? 16'hFFFF : mix_sum[ch][31:16];
         end
      end
   end

   assign rsp_valid           = vld_ff[DEPTH-1];
   assign rsp_data.shade_red   = shade_ff[0];
   assign rsp_data.shade_green = shade_ff[1];
   assign rsp_data.shade_blue  = shade_ff[2];

endmodule

`default_nettype wire

>>> sim/tb_fresnel_fog_water_shade.sv
`default_nettype none

module tb_fresnel_fog_water_shade;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   // pipeline depth plus margin for the drain at the end
   localparam int DRAIN_CYCLES   = fws_pkg::EXP_STEPS + 40;

   // exp(-2^k), Q0.24, k = -12 .. 3 (own copy for the predictor)
   localparam logic [23:0] FOG_EXP_STEP [16] = '{
      24'd16773120, 24'd16769026, 24'd16760840, 24'd16744480,
      24'd16711808, 24'd16646655, 24'd16517109, 24'd16261035,
      24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
      24'd6171993,  24'd2270549,  24'd307285,   24'd5628
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   fws_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   fws_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [2:0]       csr_index;
   logic [47:0]      csr_data;

   fresnel_fog_water_shade DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // shadow copy of the block's registers
   logic        shadow_has_ior;
   logic [15:0] shadow_captured;
   logic [1:0]  shadow_class;
   logic [15:0] shadow_bias;
   logic [15:0] shadow_density;
   logic [47:0] shadow_fog;

   fws_pkg::rsp_type pending_shades[$];
   int          error_count;
   int          idle_cycles;
   bit          rsp_hold;      // long receiver hold-off request
   bit          rsp_random_on;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic logic [63:0] round_q16(input logic [63:0] a, input logic [63:0] b);
      return (a * b + 64'd32768) >> 16;
   endfunction

   function automatic logic [63:0] predict_f0();
      logic [63:0] n;
      logic [63:0] num;
      logic [63:0] den;
      logic [15:0] b;
      bit          use_index;
      n = 0;
      use_index = 1;
      if (shadow_has_ior) begin
         if (shadow_captured < 16'd4096 || shadow_captured > 16'd16384) use_index = 0;
         else n = shadow_captured;
      end else if (shadow_class == fws_pkg::CLASS_WATER) begin
         n = 5460;
      end else if (shadow_class == fws_pkg::CLASS_GLASS) begin
         n = 6144;
      end
      if (use_index && n > 4096) begin
         num = (n - 4096) * (n - 4096);
         den = (n + 4096) * (n + 4096);
         return (num * 64'd65536 + den / 2) / den;
      end
      b = shadow_bias;
      if (b[15]) return 0;
      if (b > 16'd4096) b = 16'd4096;
      return {44'b0, b, 4'b0};
   endfunction

   function automatic logic [63:0] predict_reflectance(input logic [15:0] cosine);
      logic [63:0] f0;
      logic [63:0] c;
      logic [63:0] comp;
      logic [63:0] sq;
      logic [63:0] p5;
      logic [63:0] f;
      f0 = predict_f0();
      c = cosine[15] ? 64'd0 : {48'b0, cosine};
      comp = (64'd32768 - c) << 1;
      sq = round_q16(comp, comp);
      p5 = round_q16(round_q16(sq, sq), comp);
      f = f0 + round_q16(64'd65536 - f0, p5);
      return (f > 64'd65536) ? 64'd65536 : f;
   endfunction

   function automatic logic [63:0] predict_transmittance(input logic [15:0] path_len);
      logic [63:0] x;
      logic [63:0] xq;
      logic [63:0] t;
      x = shadow_density * path_len;
      xq = (x + (64'd1 << (15 - fws_pkg::EXP_TABLE_BITS))) >> (16 - fws_pkg::EXP_TABLE_BITS);
      if (xq >= (64'd16 << fws_pkg::EXP_TABLE_BITS)) return 0;
      t = 64'd1 << 24;
      for (int j = 0; j < fws_pkg::EXP_TABLE_BITS + 4; j++) begin
         if (xq[j]) t = (t * FOG_EXP_STEP[(j - fws_pkg::EXP_TABLE_BITS + 12) & 15]
                         + (64'd1 << 23)) >> 24;
      end
      return (t + 64'd128) >> 8;
   endfunction

   function automatic fws_pkg::rsp_type predict_shade(input fws_pkg::req_type px);
      logic [63:0] f;
      logic [63:0] t;
      logic [63:0] refl[3];
      logic [63:0] refr[3];
      logic [63:0] fogged;
      logic [63:0] r;
      logic [15:0] res[3];
      bit          fog_on;
      f = predict_reflectance(px.view_cosine);
      fog_on = shadow_density != 0 && px.water_distance != 0;
      t = fog_on ? predict_transmittance(px.water_distance) : 64'd65536;
      refl = '{px.reflect_red, px.reflect_green, px.reflect_blue};
      refr = '{px.refract_red, px.refract_green, px.refract_blue};
      for (int ch = 0; ch < 3; ch++) begin
         fogged = refr[ch];
         if (fog_on)
            fogged = (refr[ch] * t + shadow_fog[16*ch +: 16] * (64'd65536 - t)
                      + 64'd32768) >> 16;
         r = (refl[ch] * f + fogged * (64'd65536 - f) + 64'd32768) >> 16;
         res[ch] = (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
      end
      return '{shade_red: res[0], shade_green: res[1], shade_blue: res[2]};
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   function automatic int pick_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // send one request; prediction is made at acceptance (config is static then)
   // valid stays high after the accept so the next request can follow directly
   task automatic send_pixel(input fws_pkg::req_type px, input bit gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_shades.push_back(predict_shade(px));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_shades.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input fws_pkg::csr_index_type idx, input logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         fws_pkg::CSR_HAS_IOR:     shadow_has_ior  = value[0];
         fws_pkg::CSR_CAPTURED:    shadow_captured = value[15:0];
         fws_pkg::CSR_CLASS:       shadow_class    = value[1:0];
         fws_pkg::CSR_BIAS:        shadow_bias     = value[15:0];
         fws_pkg::CSR_FOG_DENSITY: shadow_density  = value[15:0];
         fws_pkg::CSR_FOG_COLOUR:  shadow_fog      = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic has_ior, input logic [15:0] cap,
                                input logic [1:0] cls, input logic [15:0] bias,
                                input logic [15:0] dens, input logic [47:0] fog);
      wait_drained();
      write_reg(fws_pkg::CSR_HAS_IOR, {47'b0, has_ior});
      write_reg(fws_pkg::CSR_CAPTURED, {32'b0, cap});
      write_reg(fws_pkg::CSR_CLASS, {46'b0, cls});
      write_reg(fws_pkg::CSR_BIAS, {32'b0, bias});
      write_reg(fws_pkg::CSR_FOG_DENSITY, {32'b0, dens});
      write_reg(fws_pkg::CSR_FOG_COLOUR, fog);
      csr_valid <= 1'b0;
   endtask

   function automatic fws_pkg::req_type random_pixel();
      fws_pkg::req_type px;
      px = {$urandom, $urandom, $urandom, $urandom};
      // mostly in-gamut colors, sometimes full-range to hit saturation
      if ($urandom_range(0, 3) != 0) begin
         px.reflect_red   = 16'($urandom_range(0, 8192));
         px.reflect_green = 16'($urandom_range(0, 8192));
         px.reflect_blue  = 16'($urandom_range(0, 8192));
         px.refract_red   = 16'($urandom_range(0, 8192));
         px.refract_green = 16'($urandom_range(0, 8192));
         px.refract_blue  = 16'($urandom_range(0, 8192));
      end
      case ($urandom_range(0, 5))
         0: px.water_distance = 16'd0;
         1: px.water_distance = 16'($urandom_range(1, 255));
         2: px.water_distance = 16'($urandom_range(1, 4095));
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0) px.view_cosine = 16'h7FFF;
      return px;
   endfunction

   function automatic fws_pkg::req_type make_pixel(input logic [15:0] c,
                                                   input logic [15:0] d);
      fws_pkg::req_type px;
      px = '{reflect_red: 16'd4096, reflect_green: 16'd2048, reflect_blue: 16'hFFFF,
             refract_red: 16'd1000, refract_green: 16'hFFFF, refract_blue: 16'd0,
             view_cosine: c, water_distance: d};
      return px;
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   task automatic test_reset_defaults();
      // unknown class, zero bias, no fog: F from bias 0
      send_pixel(make_pixel(16'h0000, 16'd0), 1'b0);
      send_pixel(make_pixel(16'h7FFF, 16'd100), 1'b0);
      send_pixel(make_pixel(16'h8000, 16'hFFFF), 1'b0);
   endtask

   task automatic test_index_sources();
      // water, glass, unused class code, captured in/out of range
      apply_setting(1'b0, 16'd4096, fws_pkg::CLASS_WATER, 16'd0, 16'd0, 48'd0);
      send_pixel(make_pixel(16'd16384, 16'd0), 1'b0);
      apply_setting(1'b0, 16'd4096, fws_pkg::CLASS_GLASS, 16'd0, 16'd0, 48'd0);
      send_pixel(make_pixel(16'd16384, 16'd0), 1'b0);
      apply_setting(1'b0, 16'd4096, 2'd3, 16'd2000, 16'd0, 48'd0);
      send_pixel(make_pixel(16'd16384, 16'd0), 1'b0);
      apply_setting(1'b1, 16'd16384, fws_pkg::CLASS_WATER, 16'd0, 16'd0, 48'd0);
      send_pixel(make_pixel(16'd0, 16'd0), 1'b0);
      apply_setting(1'b1, 16'd16385, fws_pkg::CLASS_WATER, 16'h7FFF, 16'd0, 48'd0);
      send_pixel(make_pixel(16'd20000, 16'd0), 1'b0);
      apply_setting(1'b1, 16'd4095, fws_pkg::CLASS_GLASS, 16'h8000, 16'd0, 48'd0);
      send_pixel(make_pixel(16'd20000, 16'd0), 1'b0);
      // index exactly one: bias path
      apply_setting(1'b1, 16'd4096, fws_pkg::CLASS_GLASS, 16'd3000, 16'd0, 48'd0);
      send_pixel(make_pixel(16'd30000, 16'd0), 1'b0);
   endtask

   task automatic test_fog_extremes();
      apply_setting(1'b0, 16'd0, fws_pkg::CLASS_WATER, 16'd0, 16'd256, 48'hFFFF_8000_1000);
      send_pixel(make_pixel(16'd10000, 16'd1), 1'b0);
      send_pixel(make_pixel(16'd10000, 16'd256), 1'b0);
      send_pixel(make_pixel(16'd10000, 16'd4095), 1'b0);   // exponent just under 16
      send_pixel(make_pixel(16'd10000, 16'd4096), 1'b0);   // exponent 16: zero
      send_pixel(make_pixel(16'd10000, 16'hFFFF), 1'b0);
      send_pixel(make_pixel(16'd10000, 16'd0), 1'b0);      // fog off by distance
      apply_setting(1'b0, 16'hFFFF, fws_pkg::CLASS_GLASS, 16'd0, 16'hFFFF,
                    48'hFFFF_FFFF_FFFF);
      send_pixel(make_pixel(16'd0, 16'd1), 1'b0);
      send_pixel('{default: 16'hFFFF}, 1'b0);
      send_pixel('{default: 16'h0000}, 1'b0);
   endtask

   task automatic test_backpressure();
      // receiver holds off while the sender keeps offering
      rsp_hold = 1'b1;
      for (int i = 0; i < 60; i++) send_pixel(random_pixel(), 1'b0);
      wait_drained();
   endtask

   task automatic test_random_settings();
      logic [15:0] bias;
      logic [15:0] dens;
      for (int phase = 0; phase < 19; phase++) begin
         bias = (phase % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 4200));
         case (phase % 4)
            0: dens = 16'd0;
            1: dens = 16'($urandom_range(1, 64));
            2: dens = 16'($urandom_range(1, 1024));
            default: dens = 16'($urandom);
         endcase
         apply_setting(1'($urandom_range(0, 1)),
                       ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(4000, 16500)),
                       2'($urandom_range(0, 3)), bias, dens,
                       48'({$urandom, $urandom}));
         for (int i = 0; i < 100; i++) send_pixel(random_pixel(), 1'b1);
      end
   endtask

   // ---------------------------------------------------------------
   // receiver stall generator
   // ---------------------------------------------------------------
   initial begin
      int hold;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_stall <= 1'b1;
            hold = 0;
            while (hold < 300) begin
               @(negedge clock);
               hold++;
            end
            rsp_hold = 1'b0;
         end else if (rsp_random_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat (pick_gap() + 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------
   // response checker and watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      fws_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_shades.size() == 0) begin
            $display("%0t unexpected response: actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_shades.pop_front();
            if (rsp_data.shade_red !== want.shade_red) begin
               $display("%0t shade_red mismatch: expected %h actual %h",
                        $time, want.shade_red, rsp_data.shade_red);
               error_count++;
            end
            if (rsp_data.shade_green !== want.shade_green) begin
               $display("%0t shade_green mismatch: expected %h actual %h",
                        $time, want.shade_green, rsp_data.shade_green);
               error_count++;
            end
            if (rsp_data.shade_blue !== want.shade_blue) begin
               $display("%0t shade_blue mismatch: expected %h actual %h",
                        $time, want.shade_blue, rsp_data.shade_blue);
               error_count++;
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("fresnel_fog_water_shade verification failed");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      rsp_hold = 1'b0;
      rsp_random_on = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = fws_pkg::CSR_HAS_IOR;
      csr_data = '0;
      shadow_has_ior = 1'b0;
      shadow_captured = 16'd4096;
      shadow_class = fws_pkg::CLASS_UNKNOWN;
      shadow_bias = 16'd0;
      shadow_density = 16'd0;
      shadow_fog = 48'd0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_index_sources();
      test_fog_extremes();
      test_backpressure();
      rsp_random_on = 1'b1;
      test_random_settings();
      wait_drained();

      if (error_count == 0 && pending_shades.size() == 0)
         $display("fresnel_fog_water_shade verification clean");
      else
         $display("fresnel_fog_water_shade verification failed");
      $finish;
   end

endmodule

`default_nettype wire
